### rtl/u8v_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the utf-8 stream validator
// no dependencies; imported by the classifier and the top level

package u8v_pkg;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_LEAD  = 2'd1,
        ERR_BAD_CONT  = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_err;

    // byte class masks and bounds
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] MASK_TOP3   = 8'hE0;
    localparam logic [7:0] MASK_TOP2   = 8'hC0;
    localparam logic [7:0] MASK_TOP4   = 8'hF0;
    localparam logic [7:0] MASK_TOP5   = 8'hF8;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    typedef struct packed {
        logic       bad_lead;  // byte cannot open a sequence
        logic [1:0] cont_cnt;  // continuation bytes it opens
        logic       is_cont;   // byte has the form 10xxxxxx
    } t_byte_class;

endpackage

### rtl/u8v_byte_if.sv
`timescale 1ns / 1ps
// input channel: one stream byte per beat with a last marker
// no dependencies

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/u8v_result_if.sv
`timescale 1ns / 1ps
// result channel: one verdict per stream
// no dependencies

interface u8v_result_if;
    logic       valid;
    logic       ready;
    logic       is_valid;
    logic [1:0] error_kind;

    modport source (output valid, output is_valid, output error_kind, input ready);
    modport sink   (input valid, input is_valid, input error_kind, output ready);
endinterface

### rtl/utf8_stream_validator_top.sv
`timescale 1ns / 1ps
// utf-8 stream validator: input register, per-byte check, result register
// depends on u8v_pkg, u8v_byte_if, u8v_result_if, u8v_classify
//
// usage
//   i_byte carries one stream byte per beat; last_byte marks the final byte.
//   o_result carries one beat per stream, on its final byte: is_valid and
//   error_kind (none, bad lead, bad continuation, truncated sequence).
//   the first error of a stream is kept and reported on its final byte;
//   after that the checker starts clean for the next stream.
// throughput and path
//   one byte per cycle unless a final byte waits; the per-byte check is a
//   single level of compare logic between the input register and the stream
//   state. a final byte goes from the input register to the result register.
// reset
//   i_rst_n (synchronous, active low) empties both registers and clears the
//   stream state; a stream in progress is dropped.
// stalls
//   while o_result is held by the receiver, bytes that are not final keep
//   flowing; a final byte waits in the input register until the result
//   register frees, and i_byte.ready stays low while it waits.

module utf8_stream_validator_top
    import u8v_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8v_byte_if.sink      i_byte,
    u8v_result_if.source  o_result
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // stream state
    logic [1:0]  r_expect, n_expect;
    t_err        r_err, n_err;

    // result register
    logic        r_out_vld;
    logic        r_out_ok;
    t_err        r_out_err;

    t_byte_class w_class;
    t_err        w_err_step;
    t_err        w_final_err;
    logic        w_out_free;
    logic        w_consume;
    logic        w_in_take;

    u8v_classify u_classify (
        .i_byte  (r_in_byte),
        .o_class (w_class)
    );

    assign w_out_free = !r_out_vld || o_result.ready;
    // a final byte needs room in the result register
    assign w_consume  = r_in_vld && (!r_in_last || w_out_free);
    assign w_in_take  = i_byte.valid && i_byte.ready;

    assign i_byte.ready = !r_in_vld || w_consume;

    // per-byte state update
    always_comb begin
        n_expect   = r_expect;
        w_err_step = r_err;
        if (r_err == ERR_NONE) begin
            if (r_expect != 2'd0) begin
                if (w_class.is_cont) begin
                    n_expect = r_expect - 2'd1;
                end else begin
                    w_err_step = ERR_BAD_CONT;
                    n_expect   = 2'd0;
                end
            end else if (w_class.bad_lead) begin
                w_err_step = ERR_BAD_LEAD;
            end else begin
                n_expect = w_class.cont_cnt;
            end
        end
        w_final_err = w_err_step;
        if (w_err_step == ERR_NONE && n_expect != 2'd0) begin
            w_final_err = ERR_TRUNCATED;
        end
        n_err = w_err_step;
        if (r_in_last) begin
            n_expect = 2'd0;
            n_err    = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
        if (w_in_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 2'd0;
            r_err    <= ERR_NONE;
        end else if (w_consume) begin
            r_expect <= n_expect;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_consume && r_in_last;
        end
        if (w_out_free && w_consume && r_in_last) begin
            r_out_ok  <= (w_final_err == ERR_NONE);
            r_out_err <= w_final_err;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.is_valid   = r_out_ok;
    assign o_result.error_kind = r_out_err;

    // verdict and code agree
    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_ok == (r_out_err == ERR_NONE)))
        else $error("is_valid disagrees with error_kind");

    // a final byte leaves the stream state clean
    a_clean_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> (r_expect == 2'd0 && r_err == ERR_NONE))
        else $error("stream state not cleared after final byte");

    // an error holds until the final byte
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && !r_in_last && r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("sticky error changed mid-stream");

    // once an error is kept, no continuation bytes are owed
    a_err_no_expect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (r_expect == 2'd0))
        else $error("owed count nonzero with error recorded");

    // a stored result is not lost while the receiver stalls
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |=> (r_out_vld && r_out_err == $past(r_out_err)))
        else $error("result changed while stalled");

endmodule

### rtl/u8v_classify.sv
`timescale 1ns / 1ps
// byte classifier: lead length, invalid lead and continuation form
// depends on u8v_pkg

module u8v_classify
    import u8v_pkg::*;
(
    input  logic [7:0]  i_byte,
    output t_byte_class o_class
);

    always_comb begin
        o_class          = '0;
        o_class.is_cont  = ((i_byte & MASK_TOP2) == CONT_TAG);
        if (i_byte <= ASCII_MAX) begin
            o_class.cont_cnt = 2'd0;
        end else if ((i_byte & MASK_TOP3) == LEAD2_TAG) begin
            o_class.bad_lead = (i_byte < LEAD2_MIN);
            o_class.cont_cnt = 2'd1;
        end else if ((i_byte & MASK_TOP4) == LEAD3_TAG) begin
            o_class.cont_cnt = 2'd2;
        end else if ((i_byte & MASK_TOP5) == LEAD4_TAG) begin
            o_class.bad_lead = (i_byte > LEAD4_MAX);
            o_class.cont_cnt = 2'd3;
        end else begin
            o_class.bad_lead = 1'b1;
        end
    end

endmodule
